>>> rtl/sdsr_pkg.sv
// Shared types and codes for the signed divide and square root unit.
// Used by sdsr_serial and by the top level; depends on nothing else.
package sdsr_pkg;

  // Command codes carried on the input tuser.
  localparam logic [1:0] CMD_DIV      = 2'd0;
  localparam logic [1:0] CMD_DIV_SWAP = 2'd1;
  localparam logic [1:0] CMD_SQRT     = 2'd2;

  // Update kinds carried on the output tuser.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FIRST = 2'd1;
  localparam logic [1:0] KIND_ALL   = 2'd2;

  // Control from the sequencer to the bit-serial datapath.
  typedef struct packed {
    logic start;
    logic root_mode;
  } sdsr_ctrl_t;

endpackage

>>> rtl/sdsr_serial.sv
// Bit-serial restoring datapath shared by unsigned division and square root.
// Depends on sdsr_pkg for the control struct.
module sdsr_serial #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sdsr_pkg::sdsr_ctrl_t       ctrl,
  input  logic [WORD_WIDTH-1:0]      operand_a,
  input  logic [WORD_WIDTH-1:0]      operand_b,
  output logic                       done,
  output logic [WORD_WIDTH-1:0]      quot,
  output logic [WORD_WIDTH-1:0]      rem
);
  import sdsr_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int NP = (W + 1) / 2;
  localparam int AW = 2 * NP;
  localparam int CW = $clog2(W + 1);

  logic [AW-1:0] acc;
  logic [W-1:0]  den;
  logic [W-1:0]  part;
  logic [CW-1:0] count;
  logic          busy;
  logic          root_mode;

  logic [W+1:0]  part_sh;
  logic [W+1:0]  sub;
  logic [W+1:0]  diff;
  logic          take;

  // One trial subtraction per cycle: a dividend bit or a radicand bit pair
  // is shifted into the partial remainder, then the divisor or the trial
  // root is subtracted when it fits.
  always_comb begin
    if (root_mode) begin
      part_sh = {part, acc[AW-1:AW-2]};
      sub     = {den, 2'b01};
    end else begin
      part_sh = {1'b0, part, acc[AW-1]};
      sub     = {2'b00, den};
    end
    diff = part_sh - sub;
    take = ~diff[W+1];
  end

  // Sequencing control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (ctrl.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= ctrl.root_mode ? CW'(NP) : CW'(W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Shift registers: the dividend leaves at the top while quotient bits
  // enter at the bottom; for the root the trial root grows in den.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      root_mode <= ctrl.root_mode;
      part      <= '0;
      if (ctrl.root_mode) begin
        acc <= AW'(operand_a);
        den <= '0;
      end else begin
        acc <= AW'(operand_a) << (AW - W);
        den <= operand_b;
      end
    end else if (busy) begin
      part <= take ? diff[W-1:0] : part_sh[W-1:0];
      if (root_mode) begin
        acc <= {acc[AW-3:0], 2'b00};
        den <= {den[W-2:0], take};
      end else begin
        acc <= {acc[AW-2:0], take};
      end
    end
  end

  assign quot = root_mode ? den : acc[W-1:0];
  assign rem  = part;

endmodule

>>> rtl/signed_divide_and_square_root_unit.sv
// Top level of the signed divide and square root unit: stream handshake,
// operand sign handling, result fix-up and output register.
// Depends on sdsr_pkg and sdsr_serial.
//
// Usage:
//   Input words arrive on s_axis: tuser carries the command (divide first by
//   second, divide second by first, square root of first), tdata carries the
//   two operands. Results leave on m_axis: tdata holds quotient or root,
//   remainder and absolute quotient; tuser holds the update kind.
//   A word is taken when tvalid and tready are both high.
//   Timing: a divide runs one quotient bit per cycle through the shared
//   restoring datapath, and a square root retires two radicand bits per
//   cycle. A zero divisor or an unused command skips the datapath.
//   One word is in flight at a time; s_axis_tready is high only when idle.
//   The output register lets a new word be taken while a result waits.
//   If the receiver stalls, a finished result waits in the datapath until
//   the output register frees up, and no new word is taken meanwhile.
//   Reset (rst, synchronous) empties the output and returns to idle.
module signed_divide_and_square_root_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0: first_operand, second_operand, zero padding.
  input  logic [((2*WORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic [1:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields from bit 0: quotient_or_root, remainder, abs_quotient, padding.
  output logic [((3*WORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // Fields from bit 0: update_kind.
  output logic [1:0]                             m_axis_tuser
);
  import sdsr_pkg::*;

  localparam int W        = WORD_WIDTH;
  localparam int M_DATA_W = ((3 * W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t state;

  // Job descriptor kept while the datapath runs.
  logic job_root;
  logic job_zero;
  logic neg_quot;
  logic neg_rem;

  logic [W-1:0] first_op;
  logic [W-1:0] second_op;
  logic [W-1:0] num;
  logic [W-1:0] den;
  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;
  logic         in_root;
  logic         in_zero;
  logic         accept;
  sdsr_ctrl_t   ctrl;

  logic         unit_done;
  logic [W-1:0] unit_quot;
  logic [W-1:0] unit_rem;

  logic [W-1:0] res_quot;
  logic [W-1:0] res_rem;
  logic [W-1:0] res_abs;
  logic [1:0]   res_kind;
  logic         out_free;
  logic         load_out;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign first_op      = s_axis_tdata[W-1:0];
  assign second_op     = s_axis_tdata[2*W-1:W];

  // Decode the command and take operand magnitudes.
  always_comb begin
    in_root = 1'b0;
    in_zero = 1'b0;
    num     = first_op;
    den     = second_op;
    case (s_axis_tuser)
      CMD_DIV: begin
        in_zero = (second_op == '0);
      end
      CMD_DIV_SWAP: begin
        num     = second_op;
        den     = first_op;
        in_zero = (first_op == '0);
      end
      CMD_SQRT: begin
        in_root = 1'b1;
      end
      default: begin
        in_zero = 1'b1;
      end
    endcase
    num_mag = (num[W-1] && !in_root) ? (~num + 1'b1) : num;
    den_mag = den[W-1] ? (~den + 1'b1) : den;
  end

  // Start flag first, then root mode, as laid out in the control struct.
  assign ctrl = {accept && !in_zero, in_root};

  sdsr_serial #(
    .WORD_WIDTH(W)
  ) u_serial (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .operand_a (num_mag),
    .operand_b (den_mag),
    .done      (unit_done),
    .quot      (unit_quot),
    .rem       (unit_rem)
  );

  // Apply signs to the divide results; a root passes unsigned, an empty job gives zeros.
  always_comb begin
    if (job_zero) begin
      res_quot = '0;
      res_rem  = '0;
      res_abs  = '0;
      res_kind = KIND_NONE;
    end else if (job_root) begin
      res_quot = unit_quot;
      res_rem  = '0;
      res_abs  = '0;
      res_kind = KIND_FIRST;
    end else begin
      res_quot = neg_quot ? (~unit_quot + 1'b1) : unit_quot;
      res_rem  = neg_rem ? (~unit_rem + 1'b1) : unit_rem;
      res_abs  = unit_quot;
      res_kind = KIND_ALL;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign load_out = out_free && ((state == ST_HOLD) || (state == ST_RUN && unit_done));

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= in_zero ? ST_HOLD : ST_RUN;
          end
        end
        ST_RUN: begin
          if (unit_done) begin
            state <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output payload and job descriptor.
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= M_DATA_W'({res_abs, res_rem, res_quot});
      m_axis_tuser <= res_kind;
    end
    if (accept) begin
      job_root <= in_root;
      job_zero <= in_zero;
      neg_quot <= num[W-1] ^ den[W-1];
      neg_rem  <= num[W-1];
    end
  end

`ifndef SYNTH
  // A taken word always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state != ST_IDLE))
    else $error("sdsr: accepted word did not start a job");

  // The datapath finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    unit_done |-> (state == ST_RUN))
    else $error("sdsr: datapath finished outside of a running job");

  // A word with nothing written carries all-zero data.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_NONE) |-> (m_axis_tdata == '0))
    else $error("sdsr: empty result carries data");

  // A root result leaves remainder and absolute quotient zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_FIRST) |-> (m_axis_tdata[3*W-1:W] == '0))
    else $error("sdsr: root result has nonzero upper words");

  // A full divide result has a quotient equal to its magnitude up to sign.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_ALL) |->
      ((m_axis_tdata[W-1:0] == m_axis_tdata[3*W-1:2*W]) ||
       (m_axis_tdata[W-1:0] == (~m_axis_tdata[3*W-1:2*W] + 1'b1))))
    else $error("sdsr: quotient and absolute quotient disagree");
`endif

endmodule

>>> test/signed_divide_and_square_root_unit_test.sv
// Self-checking testbench for signed_divide_and_square_root_unit: a directed table,
// then random commands, every result word checked against the table or a predictor.
// Depends on sdsr_pkg and the unit itself; reads no files.
module signed_divide_and_square_root_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdsr_pkg::*;

  localparam int W = 32;
  localparam int RANDOM_ITEMS = 480;
  localparam int CHUNK = 60;
  localparam int LONG_HOLD = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOWN_MISMATCHES = 10;
  // The fourth command code has no operation behind it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [W-1:0] first;
    logic [W-1:0] second;
  } divide_request_t;

  typedef struct packed {
    logic [W-1:0] quot;
    logic [W-1:0] rem;
    logic [W-1:0] absq;
    logic [1:0]   kind;
  } divide_answer_t;

  typedef struct packed {
    divide_request_t req;
    logic            typed;
    divide_answer_t  answer;
  } table_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [2*W-1:0]         s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [3*W-1:0]         m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  divide_answer_t pending_answers[$];
  table_row_t     directed_rows[$];
  int             mismatches = 0;
  int             answers_checked = 0;
  int             cmd_counts[4] = '{0, 0, 0, 0};
  int             zero_divisors = 0;
  int             quiet_cycles = 0;
  int             send_odds = 0;
  int             recv_odds = 0;
  logic           hold_output = 1'b0;

  signed_divide_and_square_root_unit #(.WORD_WIDTH(W)) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed division truncated toward zero; the remainder follows the dividend.
  function automatic divide_answer_t signed_quotient(logic [W-1:0] num, logic [W-1:0] den);
    divide_answer_t a;
    logic [W-1:0] num_mag, den_mag, q, m;
    a = '0;
    a.kind = KIND_NONE;
    if (den == '0) return a;
    num_mag = num[W-1] ? -num : num;
    den_mag = den[W-1] ? -den : den;
    q = num_mag / den_mag;
    m = num_mag % den_mag;
    a.quot = (num[W-1] ^ den[W-1]) ? -q : q;
    a.rem = num[W-1] ? -m : m;
    a.absq = q;
    a.kind = KIND_ALL;
    return a;
  endfunction

  // Floor square root, built one root bit at a time from the top by trial squaring.
  function automatic logic [W-1:0] floor_sqrt(logic [W-1:0] v);
    logic [2*W-1:0] root, cand;
    root = '0;
    for (int i = (W + 1) / 2 - 1; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= {{W{1'b0}}, v}) root = cand;
    end
    return root[W-1:0];
  endfunction

  function automatic divide_answer_t divide_or_root(divide_request_t r);
    divide_answer_t a;
    a = '0;
    a.kind = KIND_NONE;
    case (r.cmd)
      CMD_DIV:      a = signed_quotient(r.first, r.second);
      CMD_DIV_SWAP: a = signed_quotient(r.second, r.first);
      CMD_SQRT: begin
        a.quot = floor_sqrt(r.first);
        a.kind = KIND_FIRST;
      end
      default: a.kind = KIND_NONE;
    endcase
    return a;
  endfunction

  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] v;
    int s;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: begin
        s = $urandom_range(0, 40);
        v = s - 20;
      end
      2: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 1;
          2: v = '1;
          3: v = {1'b1, {(W-1){1'b0}}};
          4: v = {1'b0, {(W-1){1'b1}}};
          default: v = {1'b1, {(W-2){1'b0}}, 1'b1};
        endcase
      end
      3: begin
        v = {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = $urandom >> $urandom_range(0, W - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic divide_request_t random_request();
    divide_request_t r;
    logic [W-1:0] seed;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.cmd = CMD_DIV;
    else if (pick < 70) r.cmd = CMD_DIV_SWAP;
    else if (pick < 97) r.cmd = CMD_SQRT;
    else r.cmd = CMD_UNUSED;
    r.first = random_operand();
    r.second = random_operand();
    // Radicands lean toward perfect squares and their neighbors below.
    if (r.cmd == CMD_SQRT) begin
      seed = $urandom_range(1, 65535);
      case ($urandom_range(0, 3))
        0: r.first = $urandom;
        1: r.first = seed * seed;
        2: r.first = seed * seed - 1;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [W-1:0] first,
                         input logic [W-1:0] second, input logic typed,
                         input logic [W-1:0] quot, input logic [W-1:0] rem,
                         input logic [W-1:0] absq, input logic [1:0] kind);
    table_row_t row;
    row.req = '{cmd: cmd, first: first, second: second};
    row.typed = typed;
    row.answer = '{quot: quot, rem: rem, absq: absq, kind: kind};
    directed_rows.push_back(row);
  endtask

  // Offer one word and hold it until taken; the expectation is queued on acceptance.
  task automatic send_command(input divide_request_t req, input divide_answer_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req.cmd;
    s_axis_tdata <= {req.second, req.first};
    do @(posedge clk); while (!s_axis_tready);
    pending_answers.push_back(want);
    cmd_counts[req.cmd]++;
    if (want.kind == KIND_NONE && req.cmd != CMD_UNUSED) zero_divisors++;
  endtask

  task automatic sender_gap();
    int gap;
    if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input divide_answer_t want,
                                 input divide_answer_t got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("%0t: %s: expected q=%h r=%h abs=%h kind=%0d, got q=%h r=%h abs=%h kind=%0d",
               $realtime, what, want.quot, want.rem, want.absq, want.kind,
               got.quot, got.rem, got.absq, got.kind);
  endtask

  // Compare every result word taken with the oldest expectation.
  always @(posedge clk) begin
    divide_answer_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.quot = m_axis_tdata[W-1:0];
      got.rem = m_axis_tdata[2*W-1:W];
      got.absq = m_axis_tdata[3*W-1:2*W];
      got.kind = m_axis_tuser;
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (got.quot !== want.quot || got.rem !== want.rem ||
            got.absq !== want.absq || got.kind !== want.kind)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // Count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: random stalls, plus one long hold while the input keeps offering.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
        gap = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Reset, directed table, random commands, drain and verdict.
  initial begin
    divide_request_t req;
    divide_answer_t want;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_DIV;

    // Signs of operands, overflow wrap, zero divisors, extremes and root edges.
    add_row(CMD_DIV, 32'd7, 32'd2, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV, -32'sd7, 32'd2, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV, 32'd7, -32'sd2, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV, -32'sd7, -32'sd2, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
            32'h8000_0000, 32'h0, 32'h8000_0000, KIND_ALL);
    add_row(CMD_DIV_SWAP, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
            32'h8000_0000, 32'h0, 32'h8000_0000, KIND_ALL);
    add_row(CMD_DIV, 32'h1234_5678, 32'h0, 1'b1, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV_SWAP, 32'h0, 32'hFFFF_FFFF, 1'b1, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV, 32'h0, 32'd5, 1'b1, '0, '0, '0, KIND_ALL);
    add_row(CMD_DIV, 32'h7FFF_FFFF, 32'd1, 1'b1,
            32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, KIND_ALL);
    add_row(CMD_DIV, 32'h8000_0000, 32'd1, 1'b1,
            32'h8000_0000, 32'h0, 32'h8000_0000, KIND_ALL);
    add_row(CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1, 32'h0, 32'd1, KIND_ALL);
    add_row(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
            32'h0, 32'h7FFF_FFFF, 32'h0, KIND_ALL);
    add_row(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'd1, 32'h0, 32'd1, KIND_ALL);
    add_row(CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV_SWAP, 32'd3, 32'd100, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_DIV_SWAP, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_SQRT, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0, 32'h0, KIND_FIRST);
    add_row(CMD_SQRT, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0000_FFFF, 32'h0, 32'h0, KIND_FIRST);
    add_row(CMD_SQRT, 32'd1, 32'h0, 1'b1, 32'd1, 32'h0, 32'h0, KIND_FIRST);
    add_row(CMD_SQRT, 32'hFFFE_0001, 32'h0, 1'b1, 32'h0000_FFFF, 32'h0, 32'h0, KIND_FIRST);
    add_row(CMD_SQRT, 32'hFFFE_0000, 32'h0, 1'b1, 32'h0000_FFFE, 32'h0, 32'h0, KIND_FIRST);
    add_row(CMD_SQRT, 32'h4000_0000, 32'hFFFF_FFFF, 1'b1,
            32'h0000_8000, 32'h0, 32'h0, KIND_FIRST);
    add_row(CMD_SQRT, 32'd24, 32'h0, 1'b0, '0, '0, '0, KIND_NONE);
    add_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, '0, '0, KIND_NONE);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].answer
                                    : divide_or_root(directed_rows[i].req);
      send_command(directed_rows[i].req, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Idling mix changes per chunk; the final chunk runs flat out.
      if (n % CHUNK == 0) begin
        if (n >= RANDOM_ITEMS - CHUNK) begin
          send_odds = 0;
          recv_odds = 0;
        end else begin
          send_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
          recv_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
        end
      end
      if (n == 100) hold_output = 1'b1;
      // Let the unit drain completely once before carrying on.
      if (n == 300) begin
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
      sender_gap();
      req = random_request();
      send_command(req, divide_or_root(req));
    end

    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (W + 8) @(posedge clk);

    $display("Covered %0d divides, %0d swapped divides, %0d roots, %0d unused commands.",
             cmd_counts[CMD_DIV], cmd_counts[CMD_DIV_SWAP], cmd_counts[CMD_SQRT],
             cmd_counts[CMD_UNUSED]);
    $display("Checked %0d results, %0d with a zero divisor; %0d mismatches.",
             answers_checked, zero_divisors, mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
